// ----- sv/gbns_pkg.sv -----
// Shared types and constants of the go-back-n sender.
package gbns_pkg;

  localparam int SEQ_W  = 16;
  localparam int PAY_W  = 64;
  localparam int MODE_W = 2;
  localparam int TMR_W  = 2;
  localparam int CFG_W  = 4;

  localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

  localparam logic [TMR_W-1:0] TMR_NONE    = 2'd0;
  localparam logic [TMR_W-1:0] TMR_START   = 2'd1;
  localparam logic [TMR_W-1:0] TMR_STOP    = 2'd2;
  localparam logic [TMR_W-1:0] TMR_RESTART = 2'd3;

  // register index as seen on paddr[2]
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 4'd8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // command from front to back; for a resend, tx_seq holds the base sequence
  typedef struct packed {
    logic              resend;
    logic              wr_en;
    logic              accepted;
    logic              window_full;
    logic              tx_valid;
    logic [SEQ_W-1:0]  tx_seq;
    logic [PAY_W-1:0]  tx_payload;
    logic [TMR_W-1:0]  timer_cmd;
    logic [SEQ_W-1:0]  timer_seq;
  } gbns_cmd_t;

  typedef struct packed {
    logic              accepted;
    logic              window_full;
    logic              tx_valid;
    logic [SEQ_W-1:0]  tx_seq;
    logic [PAY_W-1:0]  tx_payload;
    logic [TMR_W-1:0]  timer_cmd;
    logic [SEQ_W-1:0]  timer_seq;
    logic              last;
  } gbns_res_t;

endpackage

// ----- sv/go_back_n_sender.sv -----
// Top level of the go-back-n sender: config register, front end, queue, back end.
//
// A send, an ack, a refused send or an ignored item yields one result, one per cycle
// while out_stall is low, through the queue, read stage and output register. A
// timeout with N packets in flight yields N results, one per cycle while out_stall
// is low, oldest first, paced by the single read port of the WINDOW-entry payload
// memory, so such an item holds the back end until all N (up to WINDOW) are read.
// The front end keeps accepting into a two-entry command queue while the back end
// is busy, until that queue is full. Register window_size sits at byte address 0;
// values 0 and above WINDOW act as 1 and WINDOW.
module go_back_n_sender import gbns_pkg::*; #(
  parameter int WINDOW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [MODE_W-1:0]  mode,
  input  logic [PAY_W-1:0]   payload,
  input  logic [SEQ_W-1:0]   ack_num,
  input  logic               ack_ok,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               accepted,
  output logic               window_full,
  output logic               tx_valid,
  output logic [SEQ_W-1:0]   tx_seq,
  output logic [PAY_W-1:0]   tx_payload,
  output logic [TMR_W-1:0]   timer_cmd,
  output logic [SEQ_W-1:0]   timer_seq,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int QW    = $bits(gbns_cmd_t) + PTR_W + CNT_W;

  logic [CFG_W-1:0] window_size;

  logic             push, q_full, q_valid, q_pop;
  gbns_cmd_t        push_cmd, q_cmd;
  logic [PTR_W-1:0] push_ptr, q_ptr;
  logic [CNT_W-1:0] push_cnt, q_cnt;
  logic [QW-1:0]    q_data;
  gbns_res_t        res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? {28'd0, window_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE)) begin
      window_size <= pwdata[CFG_W-1:0];
    end
  end

  gbns_front #(.WINDOW(WINDOW)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .payload     (payload),
    .ack_num     (ack_num),
    .ack_ok      (ack_ok),
    .window_size (window_size),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd),
    .push_ptr    (push_ptr),
    .push_cnt    (push_cnt)
  );

  gbns_fifo #(.WIDTH(QW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_cmd, push_ptr, push_cnt}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  assign {q_cmd, q_ptr, q_cnt} = q_data;

  gbns_back #(.WINDOW(WINDOW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_ptr     (q_ptr),
    .q_cnt     (q_cnt),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign accepted    = res.accepted;
  assign window_full = res.window_full;
  assign tx_valid    = res.tx_valid;
  assign tx_seq      = res.tx_seq;
  assign tx_payload  = res.tx_payload;
  assign timer_cmd   = res.timer_cmd;
  assign timer_seq   = res.timer_seq;
  assign last        = res.last;

endmodule

// ----- sv/gbns_front.sv -----
// Front end: accepts items, keeps window state, issues commands to the back end.
module gbns_front import gbns_pkg::*; #(
  parameter int WINDOW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MODE_W-1:0]   mode,
  input  logic [PAY_W-1:0]    payload,
  input  logic [SEQ_W-1:0]    ack_num,
  input  logic                ack_ok,
  input  logic [CFG_W-1:0]    window_size,
  input  logic                q_full,
  output logic                push,
  output gbns_cmd_t           push_cmd,
  output logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] push_ptr,
  output logic [$clog2(WINDOW+1)-1:0] push_cnt
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [SEQ_W-1:0] base_seq, base_seq_next;
  logic [SEQ_W-1:0] next_seq, next_seq_next;
  logic [CNT_W-1:0] buf_count, buf_count_next;
  logic [PTR_W-1:0] head, head_next;

  logic [7:0]       ws_ext;
  logic [CNT_W-1:0] w_eff;
  logic [SEQ_W-1:0] off;
  logic             ack_hit;
  logic [CNT_W-1:0] slide;
  logic [SUM_W-1:0] slid_sum, tail_sum;
  logic [PTR_W-1:0] head_slid, tail_idx;
  logic             accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;

  always_comb begin
    ws_ext = {4'd0, window_size};
    if (ws_ext == 8'd0) begin
      w_eff = CNT_W'(1);
    end else if (ws_ext > 8'(WINDOW)) begin
      w_eff = CNT_W'(WINDOW);
    end else begin
      w_eff = CNT_W'(ws_ext);
    end
  end

  assign off     = ack_num - base_seq;
  assign ack_hit = ack_ok && (buf_count != '0) && (off < SEQ_W'(buf_count));
  assign slide   = CNT_W'(off) + CNT_W'(1);

  assign slid_sum  = SUM_W'(head) + SUM_W'(slide);
  assign head_slid = (slid_sum >= SUM_W'(WINDOW)) ? PTR_W'(slid_sum - SUM_W'(WINDOW))
                                                  : PTR_W'(slid_sum);
  assign tail_sum  = SUM_W'(head) + SUM_W'(buf_count);
  assign tail_idx  = (tail_sum >= SUM_W'(WINDOW)) ? PTR_W'(tail_sum - SUM_W'(WINDOW))
                                                  : PTR_W'(tail_sum);

  always_comb begin
    base_seq_next  = base_seq;
    next_seq_next  = next_seq;
    buf_count_next = buf_count;
    head_next      = head;
    push_cmd       = '0;
    push_ptr       = head;
    push_cnt       = buf_count;
    case (mode)
      MODE_SEND: begin
        if (buf_count < w_eff) begin
          push_cmd.accepted   = 1'b1;
          push_cmd.tx_valid   = 1'b1;
          push_cmd.wr_en      = 1'b1;
          push_cmd.tx_seq     = next_seq;
          push_cmd.tx_payload = payload;
          if (buf_count == '0) begin
            push_cmd.timer_cmd = TMR_START;
            push_cmd.timer_seq = next_seq;
          end
          push_ptr       = tail_idx;
          buf_count_next = buf_count + CNT_W'(1);
          next_seq_next  = next_seq + SEQ_W'(1);
        end
      end
      MODE_ACK: begin
        if (ack_hit) begin
          buf_count_next = buf_count - slide;
          base_seq_next  = ack_num + SEQ_W'(1);
          head_next      = head_slid;
          if (buf_count == slide) begin
            push_cmd.timer_cmd = TMR_STOP;
            push_cmd.timer_seq = base_seq;
          end else begin
            push_cmd.timer_cmd = TMR_RESTART;
            push_cmd.timer_seq = ack_num + SEQ_W'(1);
          end
        end
      end
      MODE_TIMEOUT: begin
        if (buf_count != '0) begin
          push_cmd.resend = 1'b1;
          push_cmd.tx_seq = base_seq;
        end
      end
      default: begin
      end
    endcase
    push_cmd.window_full = (buf_count_next >= w_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq  <= SEQ_W'(1);
      next_seq  <= SEQ_W'(1);
      buf_count <= '0;
      head      <= '0;
    end else if (accept) begin
      base_seq  <= base_seq_next;
      next_seq  <= next_seq_next;
      buf_count <= buf_count_next;
      head      <= head_next;
    end
  end

endmodule

// ----- sv/gbns_fifo.sv -----
// Short command queue between front and back end.
module gbns_fifo import gbns_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] data
);

  logic [WIDTH-1:0]  slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid = (fill != '0);
  assign data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ----- sv/gbns_back.sv -----
// Back end: payload memory, retransmit sequencing and result output register.
module gbns_back import gbns_pkg::*; #(
  parameter int WINDOW = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  gbns_cmd_t  q_cmd,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] q_ptr,
  input  logic [$clog2(WINDOW+1)-1:0] q_cnt,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output gbns_res_t  res
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [PAY_W-1:0] mem [WINDOW];
  logic [PAY_W-1:0] mem_q;

  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_inc;
  logic             last_pkt;
  logic [SUM_W-1:0] rd_sum;
  logic [PTR_W-1:0] raddr;

  logic       rd_valid;
  logic       rd_mem;
  gbns_res_t  rd;
  gbns_res_t  rd_issue;
  gbns_res_t  rd_out;

  logic out_free, rd_move, issue;

  assign out_free = !out_valid || !out_stall;
  assign rd_move  = rd_valid && out_free;
  assign issue    = q_valid && (!rd_valid || rd_move);

  assign idx_inc  = idx + CNT_W'(1);
  assign last_pkt = (idx_inc == q_cnt);
  assign q_pop    = issue && (!q_cmd.resend || last_pkt);

  assign rd_sum = SUM_W'(q_ptr) + SUM_W'(idx);
  assign raddr  = (rd_sum >= SUM_W'(WINDOW)) ? PTR_W'(rd_sum - SUM_W'(WINDOW))
                                             : PTR_W'(rd_sum);

  always_comb begin
    rd_issue             = '0;
    rd_issue.window_full = q_cmd.window_full;
    if (q_cmd.resend) begin
      rd_issue.tx_valid = 1'b1;
      rd_issue.tx_seq   = q_cmd.tx_seq + SEQ_W'(idx);
      if (idx == '0) begin
        rd_issue.timer_cmd = TMR_RESTART;
        rd_issue.timer_seq = q_cmd.tx_seq;
      end
      rd_issue.last = last_pkt;
    end else begin
      rd_issue.accepted   = q_cmd.accepted;
      rd_issue.tx_valid   = q_cmd.tx_valid;
      rd_issue.tx_seq     = q_cmd.tx_seq;
      rd_issue.tx_payload = q_cmd.tx_payload;
      rd_issue.timer_cmd  = q_cmd.timer_cmd;
      rd_issue.timer_seq  = q_cmd.timer_seq;
      rd_issue.last       = 1'b1;
    end
  end

  always_comb begin
    rd_out = rd;
    if (rd_mem) begin
      rd_out.tx_payload = mem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && q_cmd.wr_en) begin
      mem[q_ptr] <= q_cmd.tx_payload;
    end
    if (issue && q_cmd.resend) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd     <= rd_issue;
      rd_mem <= q_cmd.resend;
    end
    if (out_free && rd_valid) begin
      res <= rd_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue && q_cmd.resend) begin
        idx <= last_pkt ? '0 : idx_inc;
      end
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (rd_move) begin
        rd_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= rd_valid;
      end
    end
  end

endmodule

// ----- sv/gbns_checker.sv -----
// Port-level checker for the go-back-n sender, bound to the top level.
module gbns_checker import gbns_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [MODE_W-1:0]  mode,
  input logic [PAY_W-1:0]   payload,
  input logic [SEQ_W-1:0]   ack_num,
  input logic               ack_ok,
  input logic               out_valid,
  input logic               out_stall,
  input logic               accepted,
  input logic               window_full,
  input logic               tx_valid,
  input logic [SEQ_W-1:0]   tx_seq,
  input logic [PAY_W-1:0]   tx_payload,
  input logic [TMR_W-1:0]   timer_cmd,
  input logic [SEQ_W-1:0]   timer_seq,
  input logic               last,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [2:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tx_seq) && $stable(tx_payload)
      && $stable(last) && $stable(timer_cmd))
    else $error("result changed while stalled");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> tx_seq == '0 && tx_payload == '0)
    else $error("packet fields set on a result without transmission");

  a_accept_sends: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> tx_valid && last)
    else $error("accepted send without single transmission");

  a_timer_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && timer_cmd == TMR_NONE |-> timer_seq == '0)
    else $error("timer sequence set without timer command");

  a_start_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid && timer_cmd == TMR_START |-> accepted && timer_seq == tx_seq)
    else $error("timer start not tied to an accepted send");

endmodule

bind go_back_n_sender gbns_checker u_gbns_checker (.*);
